// ===== design/utu8_pkg.sv =====
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 transcoder.
// Depends on nothing; every other design file imports it.
package utu8_pkg;

    // Surrogate ranges, told apart by the top six bits of a code unit
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;   // 0xDC00..0xDFFF

    // Code point limits for the 1, 2 and 3 byte forms, and the offset for a pair
    localparam logic [20:0] CP_LIMIT_1B  = 21'h00080;
    localparam logic [20:0] CP_LIMIT_2B  = 21'h00800;
    localparam logic [20:0] CP_LIMIT_3B  = 21'h10000;
    localparam logic [20:0] CP_PAIR_BASE = 21'h10000;

    // Lead byte and continuation byte prefixes
    localparam logic [2:0] LEAD2_PREFIX = 3'b110;
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
    localparam logic [4:0] LEAD4_PREFIX = 5'b11110;
    localparam logic [1:0] CONT_PREFIX  = 2'b10;

    // Longest run of bytes that one code unit can cause
    localparam int unsigned RUN_MAX_BYTES = 6;
    localparam int unsigned RUN_CNT_W     = $clog2(RUN_MAX_BYTES + 1);
    localparam int unsigned RUN_IDX_W     = $clog2(RUN_MAX_BYTES);

    // Encoding of one code point: up to four bytes and their count
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } enc_t;

    // One item's worth of output bytes, handed from the builder to the serialiser
    typedef struct packed {
        logic [RUN_MAX_BYTES-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]          count;
        logic                          string_last;
    } run_t;

    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp < CP_LIMIT_1B) begin
            e.bytes[0] = {1'b0, cp[6:0]};
            e.len      = 3'd1;
        end else if (cp < CP_LIMIT_2B) begin
            e.bytes[0] = {LEAD2_PREFIX, cp[10:6]};
            e.bytes[1] = {CONT_PREFIX, cp[5:0]};
            e.len      = 3'd2;
        end else if (cp < CP_LIMIT_3B) begin
            e.bytes[0] = {LEAD3_PREFIX, cp[15:12]};
            e.bytes[1] = {CONT_PREFIX, cp[11:6]};
            e.bytes[2] = {CONT_PREFIX, cp[5:0]};
            e.len      = 3'd3;
        end else begin
            e.bytes[0] = {LEAD4_PREFIX, cp[20:18]};
            e.bytes[1] = {CONT_PREFIX, cp[17:12]};
            e.bytes[2] = {CONT_PREFIX, cp[11:6]};
            e.bytes[3] = {CONT_PREFIX, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

// ===== design/utu8_run_builder.sv =====
// Run builder: takes one code unit per word, tracks a held high surrogate and
// registers the whole run of UTF-8 bytes the unit causes. Depends on utu8_pkg.
module utu8_run_builder
    import utu8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_unit,
    input  logic        in_last,
    output logic        run_valid,
    input  logic        run_ready,
    output run_t        run
);

    logic       high_pending_reg, high_pending_next;
    logic [9:0] held_high_reg, held_high_next;
    logic       run_valid_reg, run_valid_next;
    run_t       run_reg, run_next;

    logic        accept;
    logic        is_high, is_low;
    logic        flush_held, pair, hold_new;
    logic [20:0] cp_new;
    enc_t        enc_held, enc_new;

    assign in_ready  = !run_valid_reg || run_ready;
    assign accept    = in_valid && in_ready;
    assign run_valid = run_valid_reg;
    assign run       = run_reg;

    // Classify the unit and choose what to encode
    always_comb begin
        is_high    = (in_unit[15:10] == SURR_HIGH_TAG);
        is_low     = (in_unit[15:10] == SURR_LOW_TAG);
        pair       = high_pending_reg && is_low;
        flush_held = high_pending_reg && !is_low;
        hold_new   = is_high && !in_last;
        cp_new     = pair ? (CP_PAIR_BASE + {1'b0, held_high_reg, in_unit[9:0]})
                          : {5'd0, in_unit};
        enc_held   = encode_cp({5'd0, SURR_HIGH_TAG, held_high_reg});
        enc_new    = encode_cp(cp_new);
    end

    // Assemble the run: flushed high surrogate first, then the new unit's bytes unless it is held
    always_comb begin
        run_next             = '0;
        run_next.string_last = in_last;
        if (flush_held) begin
            run_next.bytes[0] = enc_held.bytes[0];
            run_next.bytes[1] = enc_held.bytes[1];
            run_next.bytes[2] = enc_held.bytes[2];
            if (!hold_new) begin
                run_next.bytes[3] = enc_new.bytes[0];
                run_next.bytes[4] = enc_new.bytes[1];
                run_next.bytes[5] = enc_new.bytes[2];
                run_next.count    = RUN_CNT_W'(3) + RUN_CNT_W'(enc_new.len);
            end else begin
                run_next.count = RUN_CNT_W'(3);
            end
        end else if (!hold_new) begin
            run_next.bytes[0] = enc_new.bytes[0];
            run_next.bytes[1] = enc_new.bytes[1];
            run_next.bytes[2] = enc_new.bytes[2];
            run_next.bytes[3] = enc_new.bytes[3];
            run_next.count    = RUN_CNT_W'(enc_new.len);
        end
    end

    // Next state: hold a high surrogate, load or release the run register
    always_comb begin
        high_pending_next = high_pending_reg;
        held_high_next    = held_high_reg;
        run_valid_next    = run_valid_reg;
        if (run_ready) begin
            run_valid_next = 1'b0;
        end
        if (accept) begin
            high_pending_next = hold_new;
            held_high_next    = hold_new ? in_unit[9:0] : 10'd0;
            if (run_next.count != '0) begin
                run_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_pending_reg <= 1'b0;
            held_high_reg    <= 10'd0;
            run_valid_reg    <= 1'b0;
        end else begin
            high_pending_reg <= high_pending_next;
            held_high_reg    <= held_high_next;
            run_valid_reg    <= run_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept && (run_next.count != '0)) begin
            run_reg <= run_next;
        end
    end

`ifndef SYNTHESIS
    a_run_count_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        run_valid_reg |-> (run_reg.count != '0) && (run_reg.count <= RUN_CNT_W'(RUN_MAX_BYTES)))
        else $error("run register holds an empty or oversized run");

    a_last_clears_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_last) |=> !high_pending_reg)
        else $error("high surrogate still held after the last unit");
`endif

endmodule

// ===== design/utu8_byte_serialiser.sv =====
// Byte serialiser: takes a registered run of up to six bytes and sends it one
// word per cycle on the byte channel while out_ready is high. Depends on utu8_pkg.
module utu8_byte_serialiser
    import utu8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       run_valid,
    output logic       run_ready,
    input  run_t       run,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_run_last,
    output logic       out_string_last
);

    logic                 busy_reg, busy_next;
    logic [RUN_IDX_W-1:0] idx_reg, idx_next;
    run_t                 cur_reg;

    logic last_byte;
    logic load;

    assign last_byte       = (RUN_CNT_W'(idx_reg) + RUN_CNT_W'(1)) == cur_reg.count;
    assign run_ready       = !busy_reg || (out_ready && last_byte);
    assign load            = run_valid && run_ready;
    assign out_valid       = busy_reg;
    assign out_byte        = cur_reg.bytes[idx_reg];
    assign out_run_last    = last_byte;
    assign out_string_last = last_byte && cur_reg.string_last;

    // Advance through the run, load a new one when idle or at its end
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (busy_reg && out_ready) begin
            if (last_byte) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + RUN_IDX_W'(1);
            end
        end
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= run;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (RUN_CNT_W'(idx_reg) < cur_reg.count))
        else $error("byte index beyond the end of the run");

    a_idx_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && out_ready && !last_byte) |=>
            busy_reg && (idx_reg == $past(idx_reg) + RUN_IDX_W'(1)))
        else $error("byte index did not advance by one");
`endif

endmodule

// ===== design/utf16le_to_utf8_transcoder_core.sv =====
// UTF-16 to UTF-8 transcoder, top level: joins the run builder and the byte serialiser.
// Depends on utu8_pkg, utu8_run_builder and utu8_byte_serialiser.
//
// One UTF-16 code unit enters per word on s_ (s_tlast marks the string's last unit)
// and its UTF-8 bytes leave one per word on m_: 1, 2 or 3 bytes for a plain unit, 4 for a
// surrogate pair (sent when the low half arrives), 3 for a lone surrogate, up to 6 when a
// held high surrogate is flushed ahead of a new unit. A high surrogate that is not last
// is held and produces nothing. Otherwise the pace is set by the byte-wide output.
// A run register and the serialiser's own copy double-buffer the runs, so the next
// unit is taken while bytes still drain; with the serialiser idle, the first byte of
// a unit reaches m_ through the run register and then the serialiser's copy.
// m_tuser flags the last byte of each unit's run and m_tlast the last byte of the string.
module utf16le_to_utf8_transcoder_core
    import utu8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] code_unit
    input  logic        s_tlast,    // last_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] utf8_byte
    output logic        m_tuser,    // [0] run_last
    output logic        m_tlast     // string_last
);

    logic run_valid;
    logic run_ready;
    run_t run;

    utu8_run_builder u_builder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_unit   (s_tdata),
        .in_last   (s_tlast),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .run       (run)
    );

    utu8_byte_serialiser u_serialiser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .run_valid       (run_valid),
        .run_ready       (run_ready),
        .run             (run),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_byte        (m_tdata),
        .out_run_last    (m_tuser),
        .out_string_last (m_tlast)
    );

endmodule

// ===== tb/tb_utf16le_to_utf8_transcoder_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for utf16le_to_utf8_transcoder_core: drives UTF-16 code units,
// predicts the UTF-8 bytes in a scoreboard class and checks every output word in order.
// Depends only on the design files of the transcoder.
module tb_utf16le_to_utf8_transcoder_core;

    localparam int unsigned RANDOM_UNITS = 200;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned IDLE_PCT     = 28;

    // Surrogate halves, told apart by the top six bits of a unit
    localparam logic [5:0] HIGH_TAG = 6'b110110;
    localparam logic [5:0] LOW_TAG  = 6'b110111;

    // Kinds of character that the random strings are made of
    typedef enum int {
        CH_ASCII,
        CH_TWO_BYTE,
        CH_THREE_BYTE,
        CH_PAIR,
        CH_LONE_LOW,
        CH_LONE_HIGH,
        CH_ANY_UNIT
    } char_kind_e;

    // One expected output word
    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       run_last;
        logic       string_last;
    } utf8_word_t;

    class utf8_scoreboard;
        utf8_word_t  expected_q[$];
        bit          high_held;
        logic [9:0]  held_bits;
        int unsigned errors;

        function new();
            high_held = 1'b0;
            held_bits = '0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Append one word to the tail of the expectations
        function void append_word(utf8_word_t w);
            expected_q = {expected_q, w};
        endfunction

        // Queue the UTF-8 bytes of one code point, flags cleared
        function void push_code_point(logic [20:0] cp);
            utf8_word_t w;
            w = '0;
            if (cp < 21'h80) begin
                w.utf8_byte = cp[7:0];
                append_word(w);
            end else if (cp < 21'h800) begin
                w.utf8_byte = {3'b110, cp[10:6]};
                append_word(w);
                w.utf8_byte = {2'b10, cp[5:0]};
                append_word(w);
            end else if (cp < 21'h10000) begin
                w.utf8_byte = {4'b1110, cp[15:12]};
                append_word(w);
                w.utf8_byte = {2'b10, cp[11:6]};
                append_word(w);
                w.utf8_byte = {2'b10, cp[5:0]};
                append_word(w);
            end else begin
                w.utf8_byte = {5'b11110, cp[20:18]};
                append_word(w);
                w.utf8_byte = {2'b10, cp[17:12]};
                append_word(w);
                w.utf8_byte = {2'b10, cp[11:6]};
                append_word(w);
                w.utf8_byte = {2'b10, cp[5:0]};
                append_word(w);
            end
        endfunction

        // Predict the bytes caused by one accepted code unit
        function void note_unit(logic [15:0] unit, logic is_final);
            int  start;
            bit  pair_done;
            utf8_word_t w;
            start     = expected_q.size();
            pair_done = 1'b0;
            if (high_held) begin
                high_held = 1'b0;
                if (unit[15:10] == LOW_TAG) begin
                    push_code_point(21'h10000 + {1'b0, held_bits, unit[9:0]});
                    pair_done = 1'b1;
                end else begin
                    // flush the held high half on its own
                    push_code_point({5'd0, HIGH_TAG, held_bits});
                end
                held_bits = '0;
            end
            if (!pair_done) begin
                if (unit[15:10] == HIGH_TAG && !is_final) begin
                    high_held = 1'b1;
                    held_bits = unit[9:0];
                end else begin
                    push_code_point({5'd0, unit});
                end
            end
            // mark the end of this unit's run
            if (expected_q.size() > start) begin
                w             = expected_q.pop_back();
                w.run_last    = 1'b1;
                w.string_last = is_final;
                append_word(w);
            end
        endfunction

        function void report_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want,
                         got);
                errors++;
            end
        endfunction

        // Compare one accepted output word with the oldest expectation
        function void check_byte(logic [7:0] b, logic run_end, logic str_end);
            utf8_word_t w;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %02h/%b/%b", $time, b,
                         run_end, str_end);
                errors++;
            end else begin
                w = expected_q.pop_front();
                report_field("utf8_byte", w.utf8_byte, b);
                report_field("run_last", {7'd0, w.run_last}, {7'd0, run_end});
                report_field("string_last", {7'd0, w.string_last}, {7'd0, str_end});
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    utf8_scoreboard sb = new();
    bit          steady       = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned units_sent   = 0;
    int unsigned idle_cycles  = 0;

    utf16le_to_utf8_transcoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Note accepted units, check accepted bytes and watch for a stalled run
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_unit(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_byte(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("FAIL utf16le_to_utf8_transcoder_core");
                    $finish;
                end
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial begin : sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one code unit, with random gaps ahead of it, and wait for acceptance
    task automatic send_unit(input logic [15:0] unit, input logic is_final);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= is_final;
        do @(posedge aclk); while (!s_tready);
        units_sent++;
    endtask

    // Drop valid and hold until every predicted byte has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [15:0] plane0_unit();
        logic [15:0] u;
        do u = 16'($urandom_range(16'hFFFF, 16'h0800)); while (u[15:11] == 5'b11011);
        return u;
    endfunction

    // Build one string of random characters, mostly well formed, and send it
    task automatic send_string(input int n_chars);
        logic [15:0] units[$];
        int          pick;
        char_kind_e  kind;
        for (int i = 0; i < n_chars; i++) begin
            pick = $urandom_range(99);
            if (pick < 30)      kind = CH_ASCII;
            else if (pick < 48) kind = CH_TWO_BYTE;
            else if (pick < 68) kind = CH_THREE_BYTE;
            else if (pick < 88) kind = CH_PAIR;
            else if (pick < 92) kind = CH_LONE_LOW;
            else if (pick < 96) kind = CH_LONE_HIGH;
            else                kind = CH_ANY_UNIT;
            case (kind)
                CH_ASCII:      units = {units, 16'($urandom_range(16'h007F))};
                CH_TWO_BYTE:   units = {units, 16'($urandom_range(16'h07FF, 16'h0080))};
                CH_THREE_BYTE: units = {units, plane0_unit()};
                CH_PAIR: begin
                    units = {units, {HIGH_TAG, 10'($urandom)}};
                    units = {units, {LOW_TAG, 10'($urandom)}};
                end
                CH_LONE_LOW:   units = {units, {LOW_TAG, 10'($urandom)}};
                CH_LONE_HIGH:  units = {units, {HIGH_TAG, 10'($urandom)}};
                default:       units = {units, 16'($urandom)};
            endcase
        end
        foreach (units[i]) send_unit(units[i], i == units.size() - 1);
    endtask

    initial begin : stimulus
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Range edges of the 1, 2 and 3 byte forms
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Smallest and largest surrogate pairs
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Lone low halves
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // Held high, then a high that ends the string: six bytes
        send_unit(16'hD83D, 1'b0);
        send_unit(16'hD801, 1'b1);
        // High half as the last unit on its own
        send_unit(16'hDBFF, 1'b1);
        // Held high replaced by another high, then flushed ahead of a plain unit
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'h0041, 1'b0);
        // Held high across an idle spell, completed later
        send_unit(16'hD812, 1'b0);
        wait_drained();
        send_unit(16'hDC34, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b1);

        // Random strings, with one long receiver hold-off, one sender pause
        // and one stretch without idling
        units_sent = 0;
        while (units_sent < RANDOM_UNITS) begin
            if (!hold_done && units_sent >= 50) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && units_sent >= 110) begin
                wait_drained();
                pause_done = 1'b1;
            end
            steady = (units_sent >= 140 && units_sent < 175);
            send_string(int'($urandom_range(8, 1)));
        end
        steady = 1'b0;

        // Drain, then allow for anything late
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d bytes expected, actual none", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("PASS utf16le_to_utf8_transcoder_core");
        end else begin
            $display("FAIL utf16le_to_utf8_transcoder_core");
        end
        $finish;
    end

endmodule
